// ===== sv/mna_pkg.sv =====
package mna_pkg;

  // Output field widths
  localparam int unsigned WHOLE_W = 33;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DEN_W   = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_PREP,
    ST_RUN,
    ST_INIT2,
    ST_DIV2,
    ST_FIN
  } mna_state_e;

  // Operand pair fed to the shared multiplier
  typedef enum logic [1:0] {
    MUL_AD,  // num_a * den_b
    MUL_BC,  // num_b * den_a
    MUL_DD   // den_a * den_b
  } mna_mul_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;       // latch operands and error flag
    mna_mul_e mul_sel;
    logic     mul_en;
    logic     num_first;  // numerator accumulator takes the first product
    logic     num_add;    // numerator accumulator adds the second product
    logic     prep;       // take magnitudes, start gcd and first division
    logic     run;        // advance gcd and divider
    logic     div2_init;  // start the divisions by the gcd
    logic     out_load;   // capture the result
  } mna_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero_den;
    logic gcd_done;
    logic div_done;
  } mna_sts_t;

endpackage

// ===== sv/mna_ctrl.sv =====
module mna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mna_pkg::mna_sts_t sts_i,
  output mna_pkg::mna_cmd_t cmd_o
);

  mna_pkg::mna_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_room;

  assign out_room = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mna_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.zero_den ? mna_pkg::ST_FIN : mna_pkg::ST_MUL0;
        end
      end
      mna_pkg::ST_MUL0:  state_d = mna_pkg::ST_MUL1;
      mna_pkg::ST_MUL1:  state_d = mna_pkg::ST_MUL2;
      mna_pkg::ST_MUL2:  state_d = mna_pkg::ST_PREP;
      mna_pkg::ST_PREP:  state_d = mna_pkg::ST_RUN;
      mna_pkg::ST_RUN: begin
        if (sts_i.gcd_done && sts_i.div_done) begin
          state_d = mna_pkg::ST_INIT2;
        end
      end
      mna_pkg::ST_INIT2: state_d = mna_pkg::ST_DIV2;
      mna_pkg::ST_DIV2: begin
        if (sts_i.div_done) begin
          state_d = mna_pkg::ST_FIN;
        end
      end
      mna_pkg::ST_FIN: begin
        if (out_room) begin
          state_d = mna_pkg::ST_IDLE;
        end
      end
      default: state_d = mna_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.mul_sel = mna_pkg::MUL_AD;
    in_ready_o = 1'b0;
    case (state_q)
      mna_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mna_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mna_pkg::MUL_AD;
      end
      mna_pkg::ST_MUL1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = mna_pkg::MUL_BC;
        cmd_o.num_first = 1'b1;
      end
      mna_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mna_pkg::MUL_DD;
        cmd_o.num_add = 1'b1;
      end
      mna_pkg::ST_PREP:  cmd_o.prep = 1'b1;
      mna_pkg::ST_RUN:   cmd_o.run = 1'b1;
      mna_pkg::ST_INIT2: cmd_o.div2_init = 1'b1;
      mna_pkg::ST_DIV2:  cmd_o.run = 1'b1;
      mna_pkg::ST_FIN:   cmd_o.out_load = out_room;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mna_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result captured but not presented");

  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_zero_den_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.zero_den) |=> (state_q == mna_pkg::ST_FIN))
    else $error("zero denominator did not go straight to the result");

  a_gcd_before_div2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mna_pkg::ST_DIV2) |-> sts_i.gcd_done)
    else $error("division by gcd started before gcd finished");

endmodule

// ===== sv/mna_dp.sv =====
module mna_dp #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mna_pkg::mna_cmd_t                    cmd_i,
  output mna_pkg::mna_sts_t                    sts_o,
  input  logic signed [FIELD_WIDTH-1:0]        whole_a_i,
  input  logic signed [FIELD_WIDTH-1:0]        num_a_i,
  input  logic signed [FIELD_WIDTH-1:0]        den_a_i,
  input  logic signed [FIELD_WIDTH-1:0]        whole_b_i,
  input  logic signed [FIELD_WIDTH-1:0]        num_b_i,
  input  logic signed [FIELD_WIDTH-1:0]        den_b_i,
  output logic signed [mna_pkg::WHOLE_W-1:0]   whole_sum_o,
  output logic signed [mna_pkg::NUM_W-1:0]     num_sum_o,
  output logic signed [mna_pkg::DEN_W-1:0]     den_sum_o,
  output logic                                 div_error_o
);

  localparam int unsigned FW = FIELD_WIDTH;
  localparam int unsigned PW = 2 * FIELD_WIDTH;
  // Numerator sum width: exact up to 64 bits, wraps modulo 2^64 beyond
  localparam int unsigned NW = (2 * FIELD_WIDTH + 1 > 64) ? 64 : 2 * FIELD_WIDTH + 1;
  localparam int unsigned EW = (NW > mna_pkg::WHOLE_W) ? NW : mna_pkg::WHOLE_W;
  localparam int unsigned KW = $clog2(NW);
  localparam int unsigned CW = $clog2(NW + 1);

  // Operands
  logic signed [FW-1:0] wa_q, na_q, da_q, wb_q, nb_q, db_q;
  logic                 err_q;

  // Multiplier and numerator accumulator
  logic signed [FW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p_q;
  logic signed [NW-1:0] p_ext;
  logic signed [NW-1:0] num_q;

  // Magnitudes and signs
  logic [NW-1:0] mag_num, mag_den;
  logic          sn_q, sd_q;
  logic [NW-1:0] md_q;

  // Binary gcd
  logic [NW-1:0] ga_q, gb_q;
  logic [KW-1:0] k_q;
  logic [NW-1:0] gcd_val;

  // Two-lane restoring divider sharing one divisor
  logic [NW-1:0] dq0_q, dq1_q, rm0_q, rm1_q, dsor_q;
  logic [CW-1:0] cnt_q;
  logic [NW:0]   sh0, sh1, df0, df1;
  logic [NW-1:0] q_q;

  // Result
  logic [EW-1:0] wa_e, wb_e, q_e, r_e, d_e, whole_e, num_e, den_e;
  logic [mna_pkg::WHOLE_W-1:0] whole_sum_q;
  logic [mna_pkg::NUM_W-1:0]   num_sum_q;
  logic [mna_pkg::DEN_W-1:0]   den_sum_q;
  logic                        div_error_q;

  assign sts_o.zero_den = (den_a_i == '0) || (den_b_i == '0);
  assign sts_o.gcd_done = (ga_q == '0);
  assign sts_o.div_done = (cnt_q == '0);

  // Latch operands on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wa_q  <= whole_a_i;
      na_q  <= num_a_i;
      da_q  <= den_a_i;
      wb_q  <= whole_b_i;
      nb_q  <= num_b_i;
      db_q  <= den_b_i;
      err_q <= sts_o.zero_den;
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      mna_pkg::MUL_AD: begin
        ma = na_q;
        mb = db_q;
      end
      mna_pkg::MUL_BC: begin
        ma = nb_q;
        mb = da_q;
      end
      mna_pkg::MUL_DD: begin
        ma = da_q;
        mb = db_q;
      end
      default: begin
        ma = da_q;
        mb = db_q;
      end
    endcase
  end

  assign prod  = PW'(ma) * PW'(mb);
  assign p_ext = NW'(p_q);

  // Multiply, then accumulate the cross products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= prod;
    end
    if (cmd_i.num_first) begin
      num_q <= p_ext;
    end else if (cmd_i.num_add) begin
      num_q <= num_q + p_ext;
    end
  end

  assign mag_num = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
  assign mag_den = p_ext[NW-1] ? NW'(-p_ext) : NW'(p_ext);
  assign gcd_val = gb_q << k_q;

  // Binary gcd, one step per cycle while run is asserted; done when ga reaches zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sn_q <= num_q[NW-1];
      sd_q <= p_ext[NW-1];
      md_q <= mag_den;
      ga_q <= mag_num;
      gb_q <= mag_den;
      k_q  <= '0;
    end else if (cmd_i.run && (ga_q != '0)) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        k_q  <= k_q + KW'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
  end

  // Divider trial subtraction for both lanes
  assign sh0 = {rm0_q, dq0_q[NW-1]};
  assign sh1 = {rm1_q, dq1_q[NW-1]};
  assign df0 = sh0 - {1'b0, dsor_q};
  assign df1 = sh1 - {1'b0, dsor_q};

  // First pass: |num| / |den|. Second pass: |den| and remainder by the gcd.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep || cmd_i.div2_init) begin
      cnt_q <= CW'(NW);
    end else if (cmd_i.run && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dq0_q  <= mag_num;
      dq1_q  <= '0;
      rm0_q  <= '0;
      rm1_q  <= '0;
      dsor_q <= mag_den;
    end else if (cmd_i.div2_init) begin
      q_q    <= dq0_q;
      dq0_q  <= md_q;
      dq1_q  <= rm0_q;
      rm0_q  <= '0;
      rm1_q  <= '0;
      dsor_q <= gcd_val;
    end else if (cmd_i.run && (cnt_q != '0)) begin
      if (!df0[NW]) begin
        rm0_q <= df0[NW-1:0];
        dq0_q <= {dq0_q[NW-2:0], 1'b1};
      end else begin
        rm0_q <= sh0[NW-1:0];
        dq0_q <= {dq0_q[NW-2:0], 1'b0};
      end
      if (!df1[NW]) begin
        rm1_q <= df1[NW-1:0];
        dq1_q <= {dq1_q[NW-2:0], 1'b1};
      end else begin
        rm1_q <= sh1[NW-1:0];
        dq1_q <= {dq1_q[NW-2:0], 1'b0};
      end
    end
  end

  // Assemble the signed result
  assign wa_e    = EW'(wa_q);
  assign wb_e    = EW'(wb_q);
  assign q_e     = EW'(q_q);
  assign r_e     = EW'(dq1_q);
  assign d_e     = EW'(dq0_q);
  assign whole_e = wa_e + wb_e + ((sn_q ^ sd_q) ? (EW'(0) - q_e) : q_e);
  assign num_e   = sn_q ? (EW'(0) - r_e) : r_e;
  assign den_e   = sd_q ? (EW'(0) - d_e) : d_e;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      div_error_q <= err_q;
      if (err_q) begin
        whole_sum_q <= '0;
        num_sum_q   <= '0;
        den_sum_q   <= '0;
      end else begin
        whole_sum_q <= whole_e[mna_pkg::WHOLE_W-1:0];
        num_sum_q   <= num_e[mna_pkg::NUM_W-1:0];
        den_sum_q   <= den_e[mna_pkg::DEN_W-1:0];
      end
    end
  end

  assign whole_sum_o = whole_sum_q;
  assign num_sum_o   = num_sum_q;
  assign den_sum_o   = den_sum_q;
  assign div_error_o = div_error_q;

  a_gcd_b_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run && (ga_q != '0)) |-> (gb_q != '0))
    else $error("gcd operand lost while still reducing");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run && (cnt_q != '0)) |-> (dsor_q != '0))
    else $error("divider stepping with zero divisor");

  a_div2_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div2_init |-> ((ga_q == '0) && (cnt_q == '0)))
    else $error("second division started before gcd and quotient were ready");

endmodule

// ===== sv/mixed_number_adder.sv =====
// Items are handled one at a time; NW = 2*FIELD_WIDTH+1 capped at 64 (33 by default) is
// the width of the divider and binary gcd. Gcd and the first division overlap, and the
// next item is taken once the result sits in the output.
// Reset: asynchronous active low, clears the sequencer and output valid; a zero
// denominator skips the arithmetic and goes from accept straight to the result state.
module mixed_number_adder #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [FIELD_WIDTH-1:0]      whole_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      num_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      den_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      whole_b_i,
  input  logic signed [FIELD_WIDTH-1:0]      num_b_i,
  input  logic signed [FIELD_WIDTH-1:0]      den_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mna_pkg::WHOLE_W-1:0] whole_sum_o,
  output logic signed [mna_pkg::NUM_W-1:0]   num_sum_o,
  output logic signed [mna_pkg::DEN_W-1:0]   den_sum_o,
  output logic                               div_error_o
);

  mna_pkg::mna_cmd_t cmd;
  mna_pkg::mna_sts_t sts;

  // Sequencer
  mna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic
  mna_dp #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .whole_a_i   (whole_a_i),
    .num_a_i     (num_a_i),
    .den_a_i     (den_a_i),
    .whole_b_i   (whole_b_i),
    .num_b_i     (num_b_i),
    .den_b_i     (den_b_i),
    .whole_sum_o (whole_sum_o),
    .num_sum_o   (num_sum_o),
    .den_sum_o   (den_sum_o),
    .div_error_o (div_error_o)
  );

endmodule

// ===== sim/mna_checker.sv =====
`timescale 1ns / 100ps

module mna_checker #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [FIELD_WIDTH-1:0]      whole_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      num_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      den_a_i,
  input  logic signed [FIELD_WIDTH-1:0]      whole_b_i,
  input  logic signed [FIELD_WIDTH-1:0]      num_b_i,
  input  logic signed [FIELD_WIDTH-1:0]      den_b_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [mna_pkg::WHOLE_W-1:0] whole_sum_i,
  input  logic signed [mna_pkg::NUM_W-1:0]   num_sum_i,
  input  logic signed [mna_pkg::DEN_W-1:0]   den_sum_i,
  input  logic                               div_error_i,
  output int unsigned                        errors_o,
  output int unsigned                        pending_o
);

  typedef struct packed {
    logic signed [mna_pkg::WHOLE_W-1:0] whole;
    logic signed [mna_pkg::NUM_W-1:0]   num;
    logic signed [mna_pkg::DEN_W-1:0]   den;
    logic                               err;
  } mixed_sum_t;

  mixed_sum_t  expected_sums[$];
  int unsigned fail_count = 0;
  int unsigned sums_waiting = 0;

  assign errors_o  = fail_count;
  assign pending_o = sums_waiting;

  // Add two mixed numbers, reduce by the gcd and fold the quotient into the whole part
  function automatic mixed_sum_t sum_mixed(
    input logic signed [FIELD_WIDTH-1:0] wa, na, da, wb, nb, db
  );
    longint signed   num, den, whole, rem_s, den_s;
    longint unsigned mn, md, g, t, r, q;
    logic            sn, sd;
    mixed_sum_t      res;
    res = '0;
    // Zero denominator: flag it and return zeros
    if (da == 0 || db == 0) begin
      res.err = 1'b1;
      return res;
    end
    num   = longint'(na) * longint'(db) + longint'(nb) * longint'(da);
    den   = longint'(da) * longint'(db);
    whole = longint'(wa) + longint'(wb);
    sn = num[63];
    sd = den[63];
    mn = sn ? -num : num;
    md = sd ? -den : den;
    // Euclid on the magnitudes
    g = mn;
    t = md;
    while (t != 0) begin
      r = g % t;
      g = t;
      t = r;
    end
    if (g == 0) g = 64'd1;
    mn = mn / g;
    md = md / g;
    if (md == 0) md = 64'd1;
    q = mn / md;
    r = mn % md;
    whole = whole + ((sn ^ sd) ? -longint'(q) : longint'(q));
    rem_s = sn ? -longint'(r) : longint'(r);
    den_s = sd ? -longint'(md) : longint'(md);
    res.whole = whole[mna_pkg::WHOLE_W-1:0];
    res.num   = rem_s[mna_pkg::NUM_W-1:0];
    res.den   = den_s[mna_pkg::DEN_W-1:0];
    return res;
  endfunction

  // Count a failure; report only the first few
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Sample both channels on the falling edge ahead of the rising edge that takes the item
  always @(negedge clk_i) begin
    mixed_sum_t got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_sums.push_back(sum_mixed(whole_a_i, num_a_i, den_a_i,
                                          whole_b_i, num_b_i, den_b_i));
      if (out_valid_i && out_ready_i) begin
        got = '{whole_sum_i, num_sum_i, den_sum_i, div_error_i};
        if (expected_sums.size() == 0) begin
          note_failure($sformatf("unexpected result whole %0d num %0d den %0d err %0b",
                                 got.whole, got.num, got.den, got.err));
        end else begin
          want = expected_sums.pop_front();
          if (got !== want)
            note_failure($sformatf({"mismatch: expected whole %0d num %0d den %0d err %0b,",
                                    " got whole %0d num %0d den %0d err %0b"},
                                   want.whole, want.num, want.den, want.err,
                                   got.whole, got.num, got.den, got.err));
        end
      end
      sums_waiting = expected_sums.size();
    end
  end

endmodule

// ===== sim/tb_mixed_number_adder.sv =====
`timescale 1ns / 100ps

module tb_mixed_number_adder;

  localparam int unsigned FW          = 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASE_ITEMS = 175;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [FW-1:0]               whole_a_i, num_a_i, den_a_i;
  logic signed [FW-1:0]               whole_b_i, num_b_i, den_b_i;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [mna_pkg::WHOLE_W-1:0] whole_sum_o;
  logic signed [mna_pkg::NUM_W-1:0]   num_sum_o;
  logic signed [mna_pkg::DEN_W-1:0]   den_sum_o;
  logic                               div_error_o;

  int unsigned errors, pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  mixed_number_adder #(.FIELD_WIDTH(FW)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .whole_a_i   (whole_a_i),
    .num_a_i     (num_a_i),
    .den_a_i     (den_a_i),
    .whole_b_i   (whole_b_i),
    .num_b_i     (num_b_i),
    .den_b_i     (den_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .whole_sum_o (whole_sum_o),
    .num_sum_o   (num_sum_o),
    .den_sum_o   (den_sum_o),
    .div_error_o (div_error_o)
  );

  mna_checker #(.FIELD_WIDTH(FW)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .whole_a_i   (whole_a_i),
    .num_a_i     (num_a_i),
    .den_a_i     (den_a_i),
    .whole_b_i   (whole_b_i),
    .num_b_i     (num_b_i),
    .den_b_i     (den_b_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .whole_sum_i (whole_sum_o),
    .num_sum_i   (num_sum_o),
    .den_sum_i   (den_sum_o),
    .div_error_i (div_error_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input int wa, na, da, wb, nb, db);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    whole_a_i  <= FW'(wa);
    num_a_i    <= FW'(na);
    den_a_i    <= FW'(da);
    whole_b_i  <= FW'(wb);
    num_b_i    <= FW'(nb);
    den_b_i    <= FW'(db);
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  function automatic logic signed [FW-1:0] corner_value();
    case ($urandom_range(5))
      0:       return FW'(-(2 ** (FW - 1)));
      1:       return FW'(2 ** (FW - 1) - 1);
      2:       return FW'(-1);
      3:       return FW'(1);
      4:       return FW'(0);
      default: return FW'($urandom);
    endcase
  endfunction

  function automatic logic signed [FW-1:0] small_value(input int unsigned span);
    return FW'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  // Small fractions that reduce most often, plus full-range, cancelling,
  // zero-denominator and corner items
  task automatic send_random_sum();
    logic signed [FW-1:0] wa, na, da, wb, nb, db;
    int unsigned          pick;
    pick = $urandom_range(99);
    wa = FW'($urandom);
    wb = FW'($urandom);
    if (pick < 45) begin
      na = small_value(20);
      da = small_value(12);
      nb = small_value(20);
      db = small_value(12);
    end else if (pick < 75) begin
      na = FW'($urandom);
      da = FW'($urandom);
      nb = FW'($urandom);
      db = FW'($urandom);
    end else if (pick < 85) begin
      // cross terms cancel to a zero numerator
      na = FW'($urandom);
      da = FW'($urandom);
      if (da == 0) da = FW'(1);
      nb = -na;
      db = da;
    end else if (pick < 92) begin
      na = FW'($urandom);
      nb = FW'($urandom);
      da = $urandom_range(1) ? FW'(0) : FW'($urandom);
      db = (da != 0) ? FW'(0) : FW'($urandom);
    end else begin
      wa = corner_value();
      na = corner_value();
      da = corner_value();
      wb = corner_value();
      nb = corner_value();
      db = corner_value();
    end
    send_item(int'(wa), int'(na), int'(da), int'(wb), int'(nb), int'(db));
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    whole_a_i  = '0;
    num_a_i    = '0;
    den_a_i    = '0;
    whole_b_i  = '0;
    num_b_i    = '0;
    den_b_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: plain sums, improper fractions, cancelling numerators,
    // zero denominators, sign combinations and field extremes
    send_item(0, 0, 1, 0, 0, 1);
    send_item(1, 1, 2, 2, 1, 3);
    send_item(0, 7, 3, 0, 5, 4);
    send_item(0, 1, 2, 0, -1, 2);
    send_item(0, 1, -2, 0, 1, 2);
    send_item(5, 1, 0, 3, 1, 2);
    send_item(5, 1, 2, 3, 1, 0);
    send_item(0, 0, 0, 0, 0, 0);
    send_item(-32768, -32768, -32768, -32768, -32768, -32768);
    send_item(32767, 32767, 32767, 32767, 32767, 32767);
    send_item(-32768, -32768, 32767, -32768, -32768, 32767);
    send_item(32767, 32767, -32768, 32767, 32767, -32768);
    send_item(32767, -32768, -1, 32767, -32768, 1);
    send_item(-32768, 32767, 1, -32768, 32767, -1);
    send_item(0, -3, 4, 0, -1, 4);
    send_item(0, 3, -4, 0, 1, -4);
    send_item(0, -3, -4, 0, -1, -4);
    send_item(10, -7, 3, -2, 1, 6);
    send_item(-1, -1, -1, -1, -1, -1);
    send_item(0, 0, 5, 0, 0, -7);
    send_item(0, -32768, 1, 0, -32768, 1);

    // Random items under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (PHASE_ITEMS) send_random_sum();
    end
    in_valid_i <= 1'b0;

    // Drain, then watch a while for stray results
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
